// ===== sv/tcw_pkg.sv =====
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int ACTION_W  = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int ADDR_IN_W = 11;
  localparam int POS_W     = 11;

  localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0d;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h02;
  localparam int                TAB_MASK   = 7;

endpackage

// ===== sv/tcw_in_if.sv =====
interface tcw_in_if;
  import tcw_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [CHAR_W-1:0]    char_code;
  logic [ADDR_IN_W-1:0] cell_address;

  modport source (output valid, action, char_code, cell_address, input ready);
  modport sink   (input valid, action, char_code, cell_address, output ready);
endinterface

// ===== sv/tcw_out_if.sv =====
interface tcw_out_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_pos;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;

  modport source (output valid, cursor_pos, cell_char, cell_attr, input ready);
  modport sink   (input valid, cursor_pos, cell_char, cell_attr, output ready);
endinterface

// ===== sv/tcw_ram.sv =====
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/text_console_writer.sv =====
// Text console cell store with cursor. Each action is one transfer in and one transfer out;
// put (without scroll), read and the unused action are accepted, then the result is registered.
// A put that passes the last row scrolls the character memory through its single port
// pair, one cell per cycle: it moves every cell below the first row one row up, then
// zero-fills the last row and reports. A clear writes one cell per cycle, then reports.
// After reset the same fill runs over every cell with in_ch.ready low; cfg writes are taken
// at any time. A new item is taken in S_IDLE once the output register is free or being emptied.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS        = COLUMNS_DEF,
  parameter int ROWS_ON_SCREEN = ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  tcw_in_if.sink            in_ch,
  tcw_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_wdata
);

  localparam int CELLS  = COLUMNS * ROWS_ON_SCREEN;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int LIN_W  = ADDR_W + 1;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS_ON_SCREEN);
  localparam int EXT_W  = (ADDR_W > ADDR_IN_W) ? ADDR_W : ADDR_IN_W;

  typedef enum logic [2:0] {
    S_FILL, S_IDLE, S_RDWAIT, S_SCROLL, S_ZERO, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [ADDR_W-1:0]  lin_r, lin_nxt;
  logic [LIN_W-1:0]   idx_r, idx_nxt;
  logic [ATTR_W-1:0]  fill_attr_r, fill_attr_nxt;
  logic               fill_report_r, fill_report_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic [ATTR_W-1:0]  attr_cfg_r, attr_cfg_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic [ATTR_W-1:0]  out_attr_r, out_attr_nxt;

  logic               ch_we, at_we, ch_re, at_re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [CHAR_W-1:0]  ch_wdata, ch_rdata;
  logic [ATTR_W-1:0]  at_wdata, at_rdata;

  logic               in_fire, out_fire;
  logic [COL_W:0]     pc;
  logic [ROW_W:0]     pr;
  logic               p_write, p_up, p_dn, p_wrap, p_scroll;
  logic [CHAR_W-1:0]  p_char;
  logic [ADDR_W-1:0]  p_addr;
  logic [LIN_W-1:0]   lin_calc;
  logic [LIN_W-1:0]   scr_dst;
  logic [EXT_W-1:0]   addr_ext;
  logic [EXT_W-1:0]   pos_ext;

  assign in_ch.ready   = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign out_fire      = out_valid_r && out_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.cursor_pos = out_pos_r;
  assign out_ch.cell_char  = out_char_r;
  assign out_ch.cell_attr  = out_attr_r;

  assign addr_ext = EXT_W'(in_ch.cell_address);
  assign pos_ext  = EXT_W'(lin_r);
  assign scr_dst  = idx_r - LIN_W'(COLUMNS) - 1'b1;

  // put decode
  always_comb begin
    pc      = {1'b0, col_r};
    pr      = {1'b0, row_r};
    p_write = 1'b0;
    p_up    = 1'b0;
    p_dn    = 1'b0;
    p_char  = in_ch.char_code;
    p_addr  = lin_r;
    case (in_ch.char_code)
      CH_LF: begin
        pr   = pr + 1'b1;
        pc   = '0;
        p_up = 1'b1;
      end
      CH_CR: begin
        pc = '0;
      end
      CH_TAB: begin
        pc = (pc | (COL_W+1)'(TAB_MASK)) + 1'b1;
      end
      CH_BS: begin
        if (col_r != '0) begin
          pc      = pc - 1'b1;
          p_write = 1'b1;
          p_char  = BLANK_CHAR;
          p_addr  = lin_r - 1'b1;
        end else if (row_r != '0) begin
          pr      = pr - 1'b1;
          pc      = (COL_W+1)'(COLUMNS - 1);
          p_dn    = 1'b1;
          p_write = 1'b1;
          p_char  = BLANK_CHAR;
          p_addr  = lin_r - 1'b1;
        end
      end
      default: begin
        p_write = 1'b1;
        pc      = pc + 1'b1;
      end
    endcase
    p_wrap = (pc >= (COL_W+1)'(COLUMNS));
    if (p_wrap) begin
      pc = '0;
      pr = pr + 1'b1;
    end
    p_scroll = (pr >= (ROW_W+1)'(ROWS_ON_SCREEN));
    if (p_scroll) begin
      pr = (ROW_W+1)'(ROWS_ON_SCREEN - 1);
    end
    lin_calc = LIN_W'(lin_r) - LIN_W'(col_r) + LIN_W'(pc)
             + ((p_up || p_wrap) ? LIN_W'(COLUMNS) : '0)
             - (p_dn ? LIN_W'(COLUMNS) : '0);
    if (p_scroll) begin
      lin_calc = LIN_W'((ROWS_ON_SCREEN - 1) * COLUMNS);
    end
  end

  always_comb begin
    state_nxt       = state_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    lin_nxt         = lin_r;
    idx_nxt         = idx_r;
    fill_attr_nxt   = fill_attr_r;
    fill_report_nxt = fill_report_r;
    rd_ok_nxt       = rd_ok_r;
    attr_cfg_nxt    = cfg_we ? cfg_wdata : attr_cfg_r;
    out_valid_nxt   = out_fire ? 1'b0 : out_valid_r;
    out_pos_nxt     = out_pos_r;
    out_char_nxt    = out_char_r;
    out_attr_nxt    = out_attr_r;
    ch_we           = 1'b0;
    at_we           = 1'b0;
    ch_re           = 1'b0;
    at_re           = 1'b0;
    waddr           = p_addr;
    raddr           = addr_ext[ADDR_W-1:0];
    ch_wdata        = p_char;
    at_wdata        = fill_attr_r;

    case (state_r)
      S_FILL: begin
        ch_we    = 1'b1;
        at_we    = 1'b1;
        waddr    = idx_r[ADDR_W-1:0];
        ch_wdata = BLANK_CHAR;
        idx_nxt  = idx_r + 1'b1;
        if (idx_r == LIN_W'(CELLS - 1)) begin
          col_nxt   = '0;
          row_nxt   = '0;
          lin_nxt   = '0;
          state_nxt = fill_report_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.action)
            ACT_PUT: begin
              ch_we   = p_write;
              col_nxt = pc[COL_W-1:0];
              row_nxt = pr[ROW_W-1:0];
              lin_nxt = lin_calc[ADDR_W-1:0];
              if (p_scroll) begin
                idx_nxt   = LIN_W'(COLUMNS);
                state_nxt = S_SCROLL;
              end else begin
                state_nxt = S_DONE;
              end
            end
            ACT_READ: begin
              ch_re     = 1'b1;
              at_re     = 1'b1;
              rd_ok_nxt = ({1'b0, addr_ext} < (EXT_W+1)'(CELLS));
              state_nxt = S_RDWAIT;
            end
            ACT_CLEAR: begin
              fill_attr_nxt   = attr_cfg_r;
              fill_report_nxt = 1'b1;
              idx_nxt         = '0;
              state_nxt       = S_FILL;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        out_valid_nxt = 1'b1;
        out_pos_nxt   = pos_ext[POS_W-1:0];
        out_char_nxt  = rd_ok_r ? ch_rdata : '0;
        out_attr_nxt  = rd_ok_r ? at_rdata : '0;
        state_nxt     = S_IDLE;
      end
      S_SCROLL: begin
        // read cell idx, write the previous read one row up
        if (idx_r != LIN_W'(CELLS)) begin
          ch_re = 1'b1;
          raddr = idx_r[ADDR_W-1:0];
        end
        if (idx_r != LIN_W'(COLUMNS)) begin
          ch_we    = 1'b1;
          waddr    = scr_dst[ADDR_W-1:0];
          ch_wdata = ch_rdata;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LIN_W'(CELLS)) begin
          idx_nxt   = LIN_W'(CELLS - COLUMNS);
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        ch_we    = 1'b1;
        waddr    = idx_r[ADDR_W-1:0];
        ch_wdata = '0;
        idx_nxt  = idx_r + 1'b1;
        if (idx_r == LIN_W'(CELLS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_pos_nxt   = pos_ext[POS_W-1:0];
        out_char_nxt  = '0;
        out_attr_nxt  = '0;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_FILL;
      col_r         <= '0;
      row_r         <= '0;
      lin_r         <= '0;
      idx_r         <= '0;
      fill_attr_r   <= RESET_ATTR;
      fill_report_r <= 1'b0;
      rd_ok_r       <= 1'b0;
      attr_cfg_r    <= RESET_ATTR;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      lin_r         <= lin_nxt;
      idx_r         <= idx_nxt;
      fill_attr_r   <= fill_attr_nxt;
      fill_report_r <= fill_report_nxt;
      rd_ok_r       <= rd_ok_nxt;
      attr_cfg_r    <= attr_cfg_nxt;
      out_valid_r   <= out_valid_nxt;
      out_pos_r     <= out_pos_nxt;
      out_char_r    <= out_char_nxt;
      out_attr_r    <= out_attr_nxt;
    end
  end

  tcw_ram #(.WIDTH(CHAR_W), .DEPTH(CELLS)) u_char_ram (
    .clk     (clk),
    .we      (ch_we),
    .waddr   (waddr),
    .wdata   (ch_wdata),
    .re      (ch_re),
    .raddr   (raddr),
    .rd_data (ch_rdata)
  );

  tcw_ram #(.WIDTH(ATTR_W), .DEPTH(CELLS)) u_attr_ram (
    .clk     (clk),
    .we      (at_we),
    .waddr   (waddr),
    .wdata   (at_wdata),
    .re      (at_re),
    .raddr   (raddr),
    .rd_data (at_rdata)
  );

endmodule

// ===== sv/tcw_checker.sv =====
module tcw_checker import tcw_pkg::*; #(
  parameter int CELLS = COLUMNS_DEF * ROWS_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [POS_W-1:0]  cursor_pos,
  input logic [CHAR_W-1:0] cell_char,
  input logic [ATTR_W-1:0] cell_attr
);

  // one action in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  // a stalled result blocks new input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result is stalled");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CELLS > 2048) || (cursor_pos < CELLS))
    else $error("cursor position beyond screen");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cursor_pos)
      && $stable(cell_char) && $stable(cell_attr))
    else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker #(.CELLS(COLUMNS * ROWS_ON_SCREEN)) u_tcw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .cursor_pos (out_ch.cursor_pos),
  .cell_char  (out_ch.cell_char),
  .cell_attr  (out_ch.cell_attr)
);
